FILE: sv/kihs_pkg.sv
// shared types and constants for the key intern hash set
`timescale 1ns / 1ps
`default_nettype none
package kihs_pkg;
	localparam int          MAX_SLOTS = 1024;
	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_NUMBER = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} stat_t;

	// request as passed from front to back
	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key;
		logic [15:0] name_length;
		logic [63:0] hash;
	} req_t;
endpackage
`default_nettype wire

FILE: sv/kihs_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module kihs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: sv/kihs_front.sv
// front end: accepts requests, hashes keys over a short pipeline, fills the queue
`timescale 1ns / 1ps
`default_nettype none
module kihs_front
	import kihs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [1:0]  command,
	input  wire logic [63:0] key,
	input  wire logic [15:0] name_length,
	output logic             busy_out,
	output logic             q_valid,
	output req_t             q_data,
	input  wire logic        q_pop
);
	// s1: partial products of the first multiply; s2: their sum
	// s3: partial products of the second multiply; s4: their sum, the queue entry
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [1:0]  cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [63:0] key_s1, key_s2, key_s3, key_s4;
	logic [15:0] len_s1, len_s2, len_s3, len_s4;
	logic [63:0] ll_s1, ll_s3;
	logic [31:0] hl_s1, lh_s1, hl_s3, lh_s3;
	logic [63:0] h_s2, h_s4;
	logic [63:0] x0;
	logic [63:0] x1;

	assign x0 = key ^ (key >> 30);
	assign x1 = h_s2 ^ (h_s2 >> 27);

	// one request in flight from accept until queue pop
	assign busy_out = v_s1 | v_s2 | v_s3 | v_s4;
	assign q_valid  = v_s4;
	assign q_data   = '{command: cmd_s4, key: key_s4, name_length: len_s4,
		hash: h_s4 ^ (h_s4 >> 31)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				v_s4 <= 1'b1;
			end else if (q_pop) begin
				v_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			key_s1 <= key;
			len_s1 <= name_length;
			ll_s1  <= 64'(x0[31:0]) * 64'(MIX_C1[31:0]);
			hl_s1  <= x0[63:32] * MIX_C1[31:0];
			lh_s1  <= x0[31:0] * MIX_C1[63:32];
		end
		cmd_s2 <= cmd_s1;
		key_s2 <= key_s1;
		len_s2 <= len_s1;
		h_s2   <= ll_s1 + {hl_s1 + lh_s1, 32'd0};
		cmd_s3 <= cmd_s2;
		key_s3 <= key_s2;
		len_s3 <= len_s2;
		ll_s3  <= 64'(x1[31:0]) * 64'(MIX_C2[31:0]);
		hl_s3  <= x1[63:32] * MIX_C2[31:0];
		lh_s3  <= x1[31:0] * MIX_C2[63:32];
		if (v_s3) begin
			cmd_s4 <= cmd_s3;
			key_s4 <= key_s3;
			len_s4 <= len_s3;
			h_s4   <= ll_s3 + {hl_s3 + lh_s3, 32'd0};
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s3 && v_s4)) else $error("queue overrun");
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({v_s1, v_s2, v_s3, v_s4}) <= 1) else $error("more than one request in front");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop of empty queue");
endmodule
`default_nettype wire

FILE: sv/kihs_back.sv
// back end: probes the table, numbers entries, clears, produces results
`timescale 1ns / 1ps
`default_nettype none
module kihs_back
	import kihs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_data,
	input  wire logic        q_valid,
	input  wire req_t        q_data,
	output logic             q_pop,
	output logic             busy_out,
	output logic             done,
	output logic [1:0]       status,
	output logic             is_new,
	output logic [9:0]       slot,
	output logic [9:0]       dense_index,
	output logic [31:0]      pool_bytes
);
	localparam int AW = $clog2(MAX_SLOTS);
	localparam int EW = $clog2(AW + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_PROBE = 8'b00000010,
		S_CHECK = 8'b00000100,
		S_NUM   = 8'b00001000,
		S_NUMW  = 8'b00010000,
		S_DRD   = 8'b00100000,
		S_DCHK  = 8'b01000000,
		S_CLR   = 8'b10000000
	} st_t;

	st_t               st_q;
	req_t              req_q;
	logic [EW-1:0]     exp_q;
	logic [AW-1:0]     mask_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     step_q;
	logic [AW:0]       n_q;
	logic [10:0]       cnt_q;
	logic [31:0]       pool_q;
	logic [10:0]       ent_q;
	logic              clr_res_q;

	// key ram word: occupied flag on top of the key
	logic              kw, dwe;
	logic [AW-1:0]     kaddr, daddr;
	logic [64:0]       kwd, krd;
	logic [9:0]        drd, dwd;
	logic [EW-1:0]     exp_new;
	logic [AW-1:0]     nidx;
	logic [AW-1:0]     step_new;
	logic [32:0]       psum;
	logic [31:0]       psat;

	// smallest e >= 1 with 2^e >= want, capped at the table size
	always_comb begin
		exp_new = EW'(1);
		for (int i = 2; i <= AW; i++) begin
			if ((32'd1 << (i - 1)) < {21'd0, cfg_data}) begin
				exp_new = EW'(i);
			end
		end
	end

	always_comb begin
		step_new = '0;
		for (int i = 1; i <= AW; i++) begin
			if (EW'(i) == exp_q) begin
				step_new = AW'(q_data.hash >> (64 - i));
			end
		end
		step_new[0] = 1'b1;
	end

	assign nidx = (idx_q + step_q) & mask_q;
	assign psum = {1'b0, pool_q} + 33'(req_q.name_length) + 33'd1;
	assign psat = psum[32] ? 32'hffffffff : psum[31:0];

	assign kaddr = idx_q;
	assign kw    = (st_q == S_CLR) || ((st_q == S_CHECK) && !krd[64]
		&& (req_q.command == CMD_INSERT));
	assign kwd   = (st_q == S_CLR) ? 65'd0 : {1'b1, req_q.key};
	assign daddr = idx_q;
	assign dwe   = (st_q == S_NUMW) && krd[64];
	assign dwd   = cnt_q[9:0];

	kihs_ram #(.WIDTH(65), .DEPTH(MAX_SLOTS)) u_keys (
		.clk(clk), .we(kw), .addr(kaddr), .wdata(kwd), .rdata(krd));
	kihs_ram #(.WIDTH(10), .DEPTH(MAX_SLOTS)) u_dense (
		.clk(clk), .we(dwe), .addr(daddr), .wdata(dwd), .rdata(drd));

	assign q_pop    = (st_q == S_IDLE) && q_valid;
	assign busy_out = (st_q != S_IDLE);

	// probe: idx_q holds current slot, key ram read lands in S_CHECK
	// clear pass: one slot a cycle over the current table, also after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLR;
			exp_q     <= EW'(1);
			mask_q    <= AW'(1);
			idx_q     <= '0;
			clr_res_q <= 1'b0;
			pool_q    <= '0;
			ent_q     <= '0;
			done      <= 1'b0;
		end else if (cfg_we) begin
			exp_q     <= exp_new;
			mask_q    <= AW'((32'd1 << exp_new) - 32'd1);
			idx_q     <= '0;
			clr_res_q <= 1'b0;
			pool_q    <= '0;
			ent_q     <= '0;
			done      <= 1'b0;
			st_q      <= S_CLR;
		end else begin
			case (st_q)
				S_IDLE: begin
					done <= 1'b0;
					if (q_valid) begin
						req_q  <= q_data;
						step_q <= step_new;
						n_q    <= '0;
						cnt_q  <= '0;
						status <= ST_OK;
						is_new <= 1'b0;
						slot   <= '0;
						dense_index <= '0;
						case (cmd_t'(q_data.command))
							CMD_CLEAR: begin
								idx_q      <= '0;
								clr_res_q  <= 1'b1;
								pool_q     <= '0;
								ent_q      <= '0;
								pool_bytes <= '0;
								st_q       <= S_CLR;
							end
							CMD_NUMBER: begin
								idx_q <= '0;
								st_q  <= S_NUM;
							end
							default: begin
								idx_q <= (AW'(q_data.hash[31:0]) + step_new) & mask_q;
								st_q  <= S_PROBE;
							end
						endcase
					end
				end
				S_CLR: begin
					if (idx_q == mask_q) begin
						done <= clr_res_q;
						st_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_PROBE: st_q <= S_CHECK;
				S_CHECK: begin
					if (!krd[64]) begin
						if (req_q.command == CMD_INSERT) begin
							ent_q  <= ent_q + 11'd1;
							pool_q <= psat;
							pool_bytes <= psat;
							is_new <= 1'b1;
							slot   <= 10'(idx_q);
						end else begin
							status     <= ST_NOTFOUND;
							pool_bytes <= pool_q;
						end
						done <= 1'b1;
						st_q <= S_IDLE;
					end else if (krd[63:0] == req_q.key) begin
						slot <= 10'(idx_q);
						pool_bytes <= pool_q;
						if (req_q.command == CMD_INSERT) begin
							done <= 1'b1;
							st_q <= S_IDLE;
						end else begin
							st_q <= S_DRD;
						end
					end else if (n_q >= {1'b0, mask_q}) begin
						status <= (req_q.command == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
						pool_bytes <= pool_q;
						done <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						n_q   <= n_q + (AW + 1)'(1);
						idx_q <= nidx;
						st_q  <= S_PROBE;
					end
				end
				S_DRD: st_q <= S_DCHK;
				S_DCHK: begin
					if ({1'b0, drd} < ent_q) begin
						dense_index <= drd;
					end else begin
						status <= ST_NOTFOUND;
					end
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				S_NUM: st_q <= S_NUMW;
				S_NUMW: begin
					if (krd[64]) begin
						cnt_q <= cnt_q + 11'd1;
					end
					if (idx_q == mask_q) begin
						pool_bytes <= pool_q;
						done <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
						st_q  <= S_NUM;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == S_IDLE) else $error("result outside idle");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q != S_IDLE) else $error("pop lost");
	a_ent: assert property (@(posedge clk) disable iff (!arst_n)
		ent_q <= 11'(MAX_SLOTS)) else $error("entry count overflow");
endmodule
`default_nettype wire

FILE: sv/key_intern_hash_set_core.sv
// top level of the key intern hash set
`timescale 1ns / 1ps
`default_nettype none
// Interning set for 64-bit keys in an open-addressed table of up to MAX_SLOTS
// slots. Issue a request with start while busy is low; each request gives
// exactly one result, marked by done for one cycle, and the receiver cannot
// stall it. The front hashes the key (splitmix64, each multiply split into
// 32-bit partial products and a sum) into a one-entry queue; the back walks
// the probe sequence one slot at a time, each probe a key ram read then a
// compare. A lookup that finds its key also reads the dense index; number
// reads every slot of the current table in turn; clear runs a clearing pass
// of one slot a cycle. busy stays high through the result cycle, so the next
// request is taken in the cycle after the result. A write of expected_keys
// starts the same clearing pass over the new table size with busy high; after
// reset a two-slot pass holds busy high.
module key_intern_hash_set_core
	import kihs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [63:0] key,
	input  wire logic [15:0] name_length,
	output logic             done,
	output logic [1:0]       status,
	output logic             is_new,
	output logic [9:0]       slot,
	output logic [9:0]       dense_index,
	output logic [31:0]      pool_bytes
);
	logic  f_busy, b_busy, q_valid, q_pop, back_busy_q;
	req_t  q_data;

	// busy covers both halves so one request is in flight at a time
	// the back also holds it during a clearing pass
	assign busy = f_busy | back_busy_q | b_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_busy_q <= 1'b0;
		end else if (q_pop) begin
			back_busy_q <= 1'b1;
		end else if (done) begin
			back_busy_q <= 1'b0;
		end
	end

	kihs_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(start & ~busy),
		.command(command), .key(key), .name_length(name_length),
		.busy_out(f_busy), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

	kihs_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .busy_out(b_busy),
		.done(done), .status(status), .is_new(is_new), .slot(slot),
		.dense_index(dense_index), .pool_bytes(pool_bytes));

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> back_busy_q) else $error("result with no request");
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// self-checking testbench for the key intern hash set core
`timescale 1ns / 1ps
`default_nettype none
// Tests the key intern hash set with its own predictor of the table: hashing,
// double-hash probing, dedup, pool total, numbering and lookup. Every accepted
// request is predicted at once and queued; a checker pops the queue on each
// done strobe and compares the result field by field. Lookups are screened so
// that no key is ever looked up at a slot that no number request has written.
module tb_top
	import kihs_pkg::*;
();

	localparam int  SLOTS     = MAX_SLOTS;
	localparam int  LIMIT     = 20000000;
	localparam int  DRAIN_GAP = 8;

	typedef enum logic [1:0] {
		PROBE_HIT       = 2'd0,
		PROBE_FREE      = 2'd1,
		PROBE_EXHAUSTED = 2'd2
	} probe_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        is_new;
		logic [9:0]  slot;
		logic [9:0]  dense_index;
		logic [31:0] pool_bytes;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [63:0] key;
	logic [15:0] name_length;
	logic        done;
	logic [1:0]  status;
	logic        is_new;
	logic [9:0]  slot;
	logic [9:0]  dense_index;
	logic [31:0] pool_bytes;

	// shadow table state
	logic [63:0] shadow_keys [SLOTS];
	logic [9:0]  shadow_dense [SLOTS];
	bit          shadow_occ [SLOTS];
	bit          shadow_numbered [SLOTS];
	logic [31:0] shadow_pool;
	int          shadow_entries;
	int          tbl_e;

	answer_t     pending_answers [$];
	int          error_count;
	int          cycle_count;
	int          sender_idle_pct;
	logic [63:0] key_pool [$];

	key_intern_hash_set_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.key        (key),
		.name_length(name_length),
		.done       (done),
		.status     (status),
		.is_new     (is_new),
		.slot       (slot),
		.dense_index(dense_index),
		.pool_bytes (pool_bytes)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// splitmix64 finalizer
	function automatic logic [63:0] mix_key(input logic [63:0] k);
		logic [63:0] x;
		x = k ^ (k >> 30);
		x = x * 64'hbf58476d1ce4e5b9;
		x = x ^ (x >> 27);
		x = x * 64'h94d049bb133111eb;
		return x ^ (x >> 31);
	endfunction

	// smallest e >= 1 with 2^e covering the wanted count, capped at the table
	function automatic int table_exp_for(input int want);
		int e;
		int size;
		e = 1;
		size = 2;
		while (size < want && (size << 1) <= SLOTS) begin
			e++;
			size <<= 1;
		end
		return e;
	endfunction

	function automatic probe_t walk_probe(input logic [63:0] k, output int at);
		logic [63:0] h;
		logic [31:0] step;
		logic [31:0] idx;
		int          mask;
		h    = mix_key(k);
		mask = (1 << tbl_e) - 1;
		step = 32'(h >> (64 - tbl_e)) | 32'd1;
		idx  = h[31:0];
		at   = 0;
		for (int n = 0; n <= mask; n++) begin
			idx = (idx + step) & 32'(mask);
			if (!shadow_occ[idx]) begin
				at = int'(idx);
				return PROBE_FREE;
			end
			if (shadow_keys[idx] == k) begin
				at = int'(idx);
				return PROBE_HIT;
			end
		end
		return PROBE_EXHAUSTED;
	endfunction

	function automatic void empty_table();
		for (int i = 0; i < SLOTS; i++)
			shadow_occ[i] = 1'b0;
		shadow_pool    = '0;
		shadow_entries = 0;
	endfunction

	// expected answer of one accepted request, updating the shadow table
	function automatic answer_t predict_request(input cmd_t c, input logic [63:0] k,
			input logic [15:0] len);
		answer_t     a;
		probe_t      pr;
		int          at;
		int          cnt;
		logic [32:0] sum;
		a = '0;
		case (c)
			CMD_CLEAR: begin
				empty_table();
			end
			CMD_INSERT: begin
				pr = walk_probe(k, at);
				if (pr == PROBE_EXHAUSTED) begin
					a.status = ST_FULL;
				end else begin
					a.slot = 10'(at);
					if (pr == PROBE_FREE) begin
						shadow_occ[at]  = 1'b1;
						shadow_keys[at] = k;
						shadow_entries++;
						sum = {1'b0, shadow_pool} + 33'(len) + 33'd1;
						shadow_pool = sum[32] ? 32'hffffffff : sum[31:0];
						a.is_new = 1'b1;
					end
				end
			end
			CMD_NUMBER: begin
				cnt = 0;
				for (int i = 0; i < (1 << tbl_e); i++) begin
					if (shadow_occ[i]) begin
						shadow_dense[i]    = 10'(cnt);
						shadow_numbered[i] = 1'b1;
						cnt++;
					end
				end
			end
			default: begin
				pr = walk_probe(k, at);
				if (pr != PROBE_HIT) begin
					a.status = ST_NOTFOUND;
				end else begin
					a.slot = 10'(at);
					// stale index: entry may predate the latest inserts
					if (int'(shadow_dense[at]) < shadow_entries)
						a.dense_index = shadow_dense[at];
					else
						a.status = ST_NOTFOUND;
				end
			end
		endcase
		a.pool_bytes = shadow_pool;
		return a;
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// checker: one result per done strobe, compared with the oldest prediction
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d", $time, status, slot);
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					error_count++;
				end
				if (is_new !== want.is_new) begin
					$display("%0t: is_new expected %0d actual %0d", $time, want.is_new, is_new);
					error_count++;
				end
				if (slot !== want.slot) begin
					$display("%0t: slot expected %0d actual %0d", $time, want.slot, slot);
					error_count++;
				end
				if (dense_index !== want.dense_index) begin
					$display("%0t: dense_index expected %0d actual %0d", $time,
						want.dense_index, dense_index);
					error_count++;
				end
				if (pool_bytes !== want.pool_bytes) begin
					$display("%0t: pool_bytes expected %0d actual %0d", $time,
						want.pool_bytes, pool_bytes);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// issue one request; returns at the edge where it is accepted
	task automatic send_request(input cmd_t c, input logic [63:0] k, input logic [15:0] len);
		probe_t pr;
		int     at;
		cmd_t   sent;
		sent = c;
		// never look up a key sitting in a slot no number request has written
		if (c == CMD_LOOKUP) begin
			pr = walk_probe(k, at);
			if (pr == PROBE_HIT && !shadow_numbered[at])
				sent = CMD_NUMBER;
		end
		if (start && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start       <= 1'b1;
		command     <= sent;
		key         <= k;
		name_length <= len;
		do
			@(posedge clk);
		while (busy);
		pending_answers.push_back(predict_request(sent, k, len));
	endtask

	// let every outstanding result come out, then wait a quiet gap
	task automatic drain();
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// register write; only while idle, clears the table as well
	task automatic write_expected_keys(input logic [10:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		tbl_e = table_exp_for(int'(v));
		empty_table();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// smallest table, then the largest: extremes of key and length, dedup, full table, misses
	task automatic test_directed();
		write_expected_keys(11'd0);
		send_request(CMD_INSERT, 64'd0, 16'd0);
		send_request(CMD_INSERT, '1, 16'hffff);
		send_request(CMD_INSERT, 64'd0, 16'd7);
		send_request(CMD_INSERT, 64'h8000_0000_0000_0001, 16'd3);
		send_request(CMD_LOOKUP, 64'h8000_0000_0000_0001, 16'd0);
		send_request(CMD_NUMBER, 64'd0, 16'd0);
		send_request(CMD_LOOKUP, 64'd0, 16'd0);
		send_request(CMD_LOOKUP, '1, 16'd0);
		send_request(CMD_CLEAR, '1, 16'hffff);
		send_request(CMD_LOOKUP, 64'd0, 16'd0);
		send_request(CMD_INSERT, 64'h5555_aaaa_5555_aaaa, 16'd100);
		// stale index: key added after the last numbering
		send_request(CMD_LOOKUP, 64'h5555_aaaa_5555_aaaa, 16'd0);
		send_request(CMD_NUMBER, '1, 16'd0);
		send_request(CMD_LOOKUP, 64'h5555_aaaa_5555_aaaa, 16'd0);
		send_request(CMD_INSERT, 64'hdead_beef_0000_ffff, 16'h8000);
		send_request(CMD_LOOKUP, 64'hdead_beef_0000_ffff, 16'd0);
		// oversized expectation, every register bit set
		write_expected_keys(11'h7ff);
		send_request(CMD_INSERT, 64'hffff_0000_ffff_0000, 16'h7fff);
		send_request(CMD_NUMBER, 64'd0, 16'd0);
		send_request(CMD_LOOKUP, 64'hffff_0000_ffff_0000, 16'd0);
		send_request(CMD_LOOKUP, 64'h1234_5678_9abc_def0, 16'd0);
		write_expected_keys(11'd1024);
		send_request(CMD_INSERT, 64'h0f0f_0f0f_0f0f_0f0f, 16'd1);
		send_request(CMD_CLEAR, 64'd0, 16'd0);
	endtask

	// well-formed fill, number and lookup passes with some noise
	task automatic test_random(input int n_items);
		int          sent_count;
		int          size;
		int          r;
		logic [10:0] cfg_pick;
		sent_count = 0;
		while (sent_count < n_items) begin
			r = $urandom_range(99);
			if (r < 35)       cfg_pick = 11'($urandom_range(0, 3));
			else if (r < 70)  cfg_pick = 11'($urandom_range(4, 16));
			else if (r < 92)  cfg_pick = 11'($urandom_range(17, 80));
			else if (r < 97)  cfg_pick = 11'($urandom_range(81, 1024));
			else              cfg_pick = 11'($urandom_range(1025, 2047));
			write_expected_keys(cfg_pick);
			size = 1 << tbl_e;
			key_pool.delete();
			for (int i = 0; i < size + 2 && i < 48; i++)
				key_pool.push_back(rand_key());
			repeat ($urandom_range(20, 60)) begin
				r = $urandom_range(99);
				if (r < 45) begin
					send_request(CMD_INSERT, key_pool[$urandom_range(key_pool.size() - 1)],
						16'($urandom_range(0, 3) == 0 ? 16'hffff : $urandom));
				end else if (r < 75) begin
					send_request(CMD_LOOKUP, key_pool[$urandom_range(key_pool.size() - 1)],
						16'($urandom));
				end else if (r < 85) begin
					send_request(CMD_NUMBER, rand_key(), 16'($urandom));
				end else if (r < 88) begin
					send_request(CMD_CLEAR, rand_key(), 16'($urandom));
				end else begin
					send_request(cmd_t'($urandom_range(3)), rand_key(), 16'($urandom));
				end
				sent_count++;
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_data        = '0;
		start           = 1'b0;
		command         = CMD_CLEAR;
		key             = '0;
		name_length     = '0;
		error_count     = 0;
		cycle_count     = 0;
		sender_idle_pct = 27;
		tbl_e           = table_exp_for(0);
		for (int i = 0; i < SLOTS; i++) begin
			shadow_keys[i]     = '0;
			shadow_dense[i]    = '0;
			shadow_numbered[i] = 1'b0;
		end
		empty_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(400);
		sender_idle_pct = 74;
		test_random(400);
		sender_idle_pct = 0;
		test_random(400);
		drain();

		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
`default_nettype wire
